// ===== hdl/mkl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkl_pkg
// Shared types and sizes for the most-recently-used key list.
// ----------------------------------------------------------------------------
package mkl_pkg;

    localparam int ENTRIES = 6;
    localparam int KEY_W   = 32;
    localparam int POS_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic {
        MODE_ACCESS = 1'b0,
        MODE_REMOVE = 1'b1
    } mkl_mode_t;

    typedef struct packed {
        mkl_mode_t        mode;
        logic [KEY_W-1:0] key;
    } mkl_req_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       hit_position;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [2:0]       occupancy;
    } mkl_rsp_t;

    // per-cell move command; load wins over take_prev, which wins over take_next
    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
    } mkl_cell_ctrl_t;

endpackage

// ===== hdl/mkl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkl_cell
// One list slot: holds a key and its valid bit, compares against the
// request key and takes data from the front or back neighbor on command.
// ----------------------------------------------------------------------------
module mkl_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mkl_pkg::mkl_cell_ctrl_t     ctrl,
    input  logic [mkl_pkg::KEY_W-1:0]   req_key,
    input  logic [mkl_pkg::KEY_W-1:0]   prev_key,
    input  logic                        prev_valid,
    input  logic [mkl_pkg::KEY_W-1:0]   next_key,
    input  logic                        next_valid,
    output logic [mkl_pkg::KEY_W-1:0]   key,
    output logic                        valid,
    output logic                        match
);
    import mkl_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             valid_reg;
    logic             valid_next;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.load) begin
            key_next   = req_key;
            valid_next = 1'b1;
        end else if (ctrl.take_prev) begin
            key_next   = prev_key;
            valid_next = prev_valid;
        end else if (ctrl.take_next) begin
            key_next   = next_key;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (key_reg == req_key);

endmodule

// ===== hdl/mru_key_list_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_key_list_cache
// Move-to-front list of resource keys built as a row of cells. Every cell
// compares against the request key in parallel; the list then shifts by one
// place toward the back (access) or the front (remove) in the same cycle.
// ----------------------------------------------------------------------------
// Output: the result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle; the single compare-and-shift pass over
//   the cell row sets this, and the result register stalls input only while
//   a result is held against m_ready low.
// Reset: all cells invalid, occupancy zero; key storage is not cleared.
module mru_key_list_cache (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mkl_pkg::mkl_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mkl_pkg::mkl_rsp_t m_data
);
    import mkl_pkg::*;

    logic [KEY_W-1:0]  cell_key   [ENTRIES];
    logic              cell_valid [ENTRIES];
    logic [ENTRIES-1:0] cell_match;
    mkl_cell_ctrl_t    cell_ctrl  [ENTRIES];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    mkl_rsp_t          out_data_reg;
    mkl_rsp_t          out_data_next;

    logic              accept;
    logic              hit;
    logic [POS_W-1:0]  hit_pos;
    logic              full;
    logic [CNT_W-1:0]  shift_upto;
    logic              is_access;

    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_access = (s_data.mode == MODE_ACCESS);
    assign full      = (count_reg == CNT_W'(ENTRIES));
    assign hit       = |cell_match;

    // first match from the front
    always_comb begin
        hit_pos = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                hit_pos = POS_W'(i);
            end
        end
    end

    always_comb begin
        if (hit) begin
            shift_upto = CNT_W'(hit_pos);
        end else if (full) begin
            shift_upto = CNT_W'(ENTRIES - 1);
        end else begin
            shift_upto = count_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cell_ctrl[i].load      = accept && is_access && (i == 0);
            cell_ctrl[i].take_prev = accept && is_access && (i >= 1)
                                     && (CNT_W'(i) <= shift_upto);
            cell_ctrl[i].take_next = accept && !is_access && hit
                                     && (POS_W'(i) >= hit_pos);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic [KEY_W-1:0] prev_key;
            logic             prev_valid;
            logic [KEY_W-1:0] next_key;
            logic             next_valid;

            if (g == 0) begin : g_front
                assign prev_key   = '0;
                assign prev_valid = 1'b0;
            end else begin : g_mid_prev
                assign prev_key   = cell_key[g-1];
                assign prev_valid = cell_valid[g-1];
            end

            // the tail takes an empty slot when the list closes up
            if (g == ENTRIES - 1) begin : g_tail
                assign next_key   = '0;
                assign next_valid = 1'b0;
            end else begin : g_mid_next
                assign next_key   = cell_key[g+1];
                assign next_valid = cell_valid[g+1];
            end

            mkl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[g]),
                .req_key    (s_data.key),
                .prev_key   (prev_key),
                .prev_valid (prev_valid),
                .next_key   (next_key),
                .next_valid (next_valid),
                .key        (cell_key[g]),
                .valid      (cell_valid[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (is_access && !hit && !full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!is_access && hit) begin
            count_next = count_reg - CNT_W'(1);
        end

        out_data_next.hit          = hit;
        out_data_next.hit_position = hit ? 3'(hit_pos) : 3'd0;
        out_data_next.evicted      = is_access && !hit && full;
        out_data_next.evicted_key  = (is_access && !hit && full) ?
                                     cell_key[ENTRIES-1] : '0;
        out_data_next.occupancy    = 3'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== tb/mkl_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkl_tb_pkg
// Scoreboard for the most-recently-used key list: keeps its own copy of the
// list, predicts the response for every accepted request and compares each
// response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
package mkl_tb_pkg;

    import mkl_pkg::*;

    class mru_list_scoreboard;

        logic [KEY_W-1:0] list_keys[$];    // index 0 is the most recent key
        mkl_rsp_t         expected_rsp[$];
        int unsigned      mismatches;
        int unsigned      requests;
        int unsigned      removes;
        int unsigned      results;
        int unsigned      hits;
        int unsigned      evictions;
        int unsigned      absent_removes;
        int unsigned      full_seen;

        function new();
            mismatches     = 0;
            requests       = 0;
            removes        = 0;
            results        = 0;
            hits           = 0;
            evictions      = 0;
            absent_removes = 0;
            full_seen      = 0;
        endfunction

        function int unsigned pending();
            return expected_rsp.size();
        endfunction

        function void note_request(mkl_req_t req);
            mkl_rsp_t rsp;
            int       pos;

            rsp = '0;
            pos = -1;
            for (int i = 0; i < list_keys.size(); i++) begin
                if (pos < 0 && list_keys[i] == req.key)
                    pos = i;
            end
            if (pos >= 0) begin
                rsp.hit          = 1'b1;
                rsp.hit_position = 3'(pos);
                hits++;
            end
            if (list_keys.size() == ENTRIES)
                full_seen++;

            if (req.mode == MODE_ACCESS) begin
                if (pos >= 0) begin
                    list_keys.delete(pos);
                end else if (list_keys.size() >= ENTRIES) begin
                    // drop the tail entry once
                    rsp.evicted     = 1'b1;
                    rsp.evicted_key = list_keys[list_keys.size() - 1];
                    list_keys.delete(list_keys.size() - 1);
                    evictions++;
                end
                list_keys.push_front(req.key);
            end else begin
                removes++;
                if (pos >= 0)
                    list_keys.delete(pos);
                else
                    absent_removes++;
            end

            rsp.occupancy = 3'(list_keys.size());
            expected_rsp.push_back(rsp);
            requests++;
        endfunction

        task report(string field, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field,
                     got, want);
            mismatches++;
        endtask

        task check_result(mkl_rsp_t got);
            mkl_rsp_t want;

            results++;
            if (expected_rsp.size() == 0) begin
                report("unexpected response", got.evicted_key, '0);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit)
                report("hit", KEY_W'(got.hit), KEY_W'(want.hit));
            if (got.hit_position !== want.hit_position)
                report("hit_position", KEY_W'(got.hit_position),
                       KEY_W'(want.hit_position));
            if (got.evicted !== want.evicted)
                report("evicted", KEY_W'(got.evicted), KEY_W'(want.evicted));
            if (got.evicted_key !== want.evicted_key)
                report("evicted_key", got.evicted_key, want.evicted_key);
            if (got.occupancy !== want.occupancy)
                report("occupancy", KEY_W'(got.occupancy), KEY_W'(want.occupancy));
        endtask

    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Request/response test of the most-recently-used key list. A short directed
// sequence walks the list through empty, full, hits at the front and tail,
// evictions and removes of present and absent keys; random requests drawn
// from a small rotating key pool then follow, with random gaps on the request
// side and random back-pressure on the response side.
// ----------------------------------------------------------------------------
module tb_top;

    import mkl_pkg::*;
    import mkl_tb_pkg::*;

    localparam int          RANDOM_REQUESTS = 1830;
    localparam int          POOL_SIZE       = 9;
    localparam int unsigned IDLE_LIMIT      = 2000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    mkl_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    mkl_rsp_t m_data;

    mru_list_scoreboard sb;
    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    bit                 calm_send;
    bit                 calm_recv;
    int unsigned        stall_left;
    int unsigned        idle_cycles;

    mru_key_list_cache u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // response side: random stalls, with calm stretches
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm_recv && $urandom_range(0, 99) < 20)
                stall_left = pick_gap(1'b0);
        end
    end

    // note accepted requests and check responses off the same edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_request(input mkl_mode_t mode, input logic [KEY_W-1:0] key);
        mkl_req_t    req;
        int unsigned gap;

        req.mode = mode;
        req.key  = key;
        gap = pick_gap(calm_send);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // hold off new requests until every outstanding response is back
    task automatic drain_responses();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        mkl_mode_t        mode;
        logic [KEY_W-1:0] key;
        int unsigned      r;

        sb          = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        calm_send   = 1'b0;
        calm_recv   = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
        foreach (key_pool[i])
            key_pool[i] = $urandom();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty list, fill, hits at both ends, eviction, removes
        send_request(MODE_REMOVE, 32'h0000_0005);
        send_request(MODE_ACCESS, 32'h0000_0000);
        send_request(MODE_REMOVE, 32'h0000_0005);
        send_request(MODE_ACCESS, 32'hFFFF_FFFF);
        send_request(MODE_ACCESS, 32'h0000_0001);
        send_request(MODE_ACCESS, 32'h8000_0000);
        send_request(MODE_ACCESS, 32'hAAAA_AAAA);
        send_request(MODE_ACCESS, 32'h5555_5555);
        send_request(MODE_ACCESS, 32'h0000_0000);
        send_request(MODE_ACCESS, 32'h0000_0000);
        send_request(MODE_ACCESS, 32'h1234_5678);
        send_request(MODE_ACCESS, 32'hFFFF_FFFE);
        send_request(MODE_REMOVE, 32'h0000_7777);
        send_request(MODE_REMOVE, 32'hFFFF_FFFE);
        send_request(MODE_REMOVE, 32'h8000_0000);
        send_request(MODE_REMOVE, 32'h0000_0000);
        send_request(MODE_ACCESS, 32'h8000_0000);
        send_request(MODE_ACCESS, 32'h0000_0001);
        send_request(MODE_REMOVE, 32'h0000_0001);
        send_request(MODE_REMOVE, 32'h8000_0000);
        send_request(MODE_REMOVE, 32'h1234_5678);
        send_request(MODE_REMOVE, 32'h5555_5555);
        send_request(MODE_REMOVE, 32'hAAAA_AAAA);
        send_request(MODE_REMOVE, 32'hAAAA_AAAA);
        drain_responses();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 120 == 0) begin
                calm_send = ($urandom_range(0, 3) == 0);
                calm_recv = ($urandom_range(0, 3) == 0);
            end
            if (n % 400 == 399)
                drain_responses();
            // rotate the pool now and then so old keys age out
            if ($urandom_range(0, 99) < 4) begin
                r = $urandom_range(0, 9);
                key_pool[$urandom_range(0, POOL_SIZE - 1)] =
                    (r == 0) ? '0 : (r == 1) ? '1 : $urandom();
            end
            mode = ($urandom_range(0, 99) < 25) ? MODE_REMOVE : MODE_ACCESS;
            key  = ($urandom_range(0, 99) < 88) ? pool_key() : $urandom();
            send_request(mode, key);
        end

        drain_responses();
        repeat (8) @(posedge aclk);

        $display("covered %0d requests (%0d removes, %0d of absent keys), %0d responses",
                 sb.requests, sb.removes, sb.absent_removes, sb.results);
        $display("list hits %0d, evictions %0d, requests against a full list %0d",
                 sb.hits, sb.evictions, sb.full_seen);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mkl_pkg.sv
hdl/mkl_cell.sv
hdl/mru_key_list_cache.sv
tb/mkl_tb_pkg.sv
tb/tb_top.sv
